// File: sv/assert_macros.svh
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk_i, off while in reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same, without a reset guard.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: sv/mtv_pkg.sv
package mtv_pkg;

  localparam int unsigned SampleW       = 16;
  localparam int unsigned CoordFracBits = 17;
  localparam int unsigned CoordW        = CoordFracBits + 1;
  localparam int unsigned TolW          = 15;

  typedef struct packed {
    logic signed [SampleW-1:0] corner_7;
    logic signed [SampleW-1:0] corner_6;
    logic signed [SampleW-1:0] corner_5;
    logic signed [SampleW-1:0] corner_4;
    logic signed [SampleW-1:0] corner_3;
    logic signed [SampleW-1:0] corner_2;
    logic signed [SampleW-1:0] corner_1;
    logic signed [SampleW-1:0] corner_0;
  } voxel_t;

  typedef struct packed {
    logic [CoordW-1:0] vert_a_x;
    logic [CoordW-1:0] vert_a_y;
    logic [CoordW-1:0] vert_a_z;
    logic [CoordW-1:0] vert_b_x;
    logic [CoordW-1:0] vert_b_y;
    logic [CoordW-1:0] vert_b_z;
    logic [CoordW-1:0] vert_c_x;
    logic [CoordW-1:0] vert_c_y;
    logic [CoordW-1:0] vert_c_z;
    logic [2:0]        tetra_index;
    logic              last_triangle;
  } tri_t;

  // ring of tetrahedron corners around the 0-7 diagonal
  function automatic logic [2:0] ring_corner(input logic [2:0] i);
    logic [2:0] r;
    unique case (i)
      3'd0: r = 3'd6;
      3'd1: r = 3'd4;
      3'd2: r = 3'd5;
      3'd3: r = 3'd1;
      3'd4: r = 3'd3;
      3'd5: r = 3'd2;
      default: r = 3'd6;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] tri_count(input logic [3:0] key);
    logic [1:0] n;
    unique case (key)
      4'd0, 4'd15: n = 2'd0;
      4'd3, 4'd5, 4'd6, 4'd9, 4'd10, 4'd12: n = 2'd2;
      default: n = 2'd1;
    endcase
    return n;
  endfunction

  // edge (filled pos, empty pos) packed as {f[1:0], e[1:0]} per vertex,
  // three vertices per triangle, vertex 0 in the low nibble
  function automatic logic [11:0] edge_row(input logic [3:0] key, input logic tri_i);
    logic [11:0] r;
    unique case ({key, tri_i})
      5'b0001_0: r = {4'b0011, 4'b0001, 4'b0010};
      5'b0010_0: r = {4'b0111, 4'b0110, 4'b0100};
      5'b0011_0: r = {4'b0011, 4'b0111, 4'b0110};
      5'b0011_1: r = {4'b0110, 4'b0010, 4'b0011};
      5'b0100_0: r = {4'b1001, 4'b1011, 4'b1000};
      5'b0101_0: r = {4'b1001, 4'b1011, 4'b0011};
      5'b0101_1: r = {4'b0011, 4'b0001, 4'b1001};
      5'b0110_0: r = {4'b1011, 4'b1000, 4'b0100};
      5'b0110_1: r = {4'b0100, 4'b0111, 4'b1011};
      5'b0111_0: r = {4'b0011, 4'b0111, 4'b1011};
      5'b1000_0: r = {4'b1110, 4'b1101, 4'b1100};
      5'b1001_0: r = {4'b0001, 4'b0010, 4'b1110};
      5'b1001_1: r = {4'b1110, 4'b1101, 4'b0001};
      5'b1010_0: r = {4'b1100, 4'b1110, 4'b0110};
      5'b1010_1: r = {4'b0110, 4'b0100, 4'b1100};
      5'b1011_0: r = {4'b0010, 4'b1110, 4'b0110};
      5'b1100_0: r = {4'b1001, 4'b1101, 4'b1100};
      5'b1100_1: r = {4'b1100, 4'b1000, 4'b1001};
      5'b1101_0: r = {4'b0001, 4'b1001, 4'b1101};
      5'b1110_0: r = {4'b1000, 4'b0100, 4'b1100};
      default:   r = 12'd0;
    endcase
    return r;
  endfunction

endpackage

// File: sv/mtv_lerp_unit.sv
// One linear blend: registered multiply stage, then rounded sum and floor-shift.
module mtv_lerp_unit #(
  parameter int unsigned FracBits = 17,
  parameter int unsigned SampleW  = 16
) (
  input  logic                       clk_i,
  input  logic signed [SampleW+1:0]  a_i,
  input  logic signed [SampleW+1:0]  b_i,
  input  logic        [FracBits:0]   t_i,
  output logic signed [SampleW+1:0]  r_o
);
  localparam int unsigned ProdW = SampleW + FracBits + 4;

  logic signed [ProdW-1:0] pa_q, pb_q;
  logic signed [ProdW-1:0] sum;
  logic        [FracBits+1:0] one_minus_t;

  assign one_minus_t = (FracBits+2)'(1 << FracBits) - {1'b0, t_i};

  always_ff @(posedge clk_i) begin
    pa_q <= ProdW'(a_i) * $signed({1'b0, one_minus_t});
    pb_q <= ProdW'(b_i) * $signed({2'b0, t_i});
  end

  // arithmetic shift floors, as the blend requires
  assign sum = pa_q + pb_q + ProdW'(1 << (FracBits - 1));
  assign r_o = (SampleW+2)'(sum >>> FracBits);
endmodule

// File: sv/mtv_search.sv
// Binary search of the trilinear interpolant along one edge.
// Seven blends per probe on the shared lerp unit.
module mtv_search #(
  parameter int unsigned SearchSteps = 16,
  parameter int unsigned FracBits    = 17,
  parameter int unsigned SampleW     = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           go_i,
  input  logic [2:0]                     v0_i,
  input  logic [2:0]                     v1_i,
  input  logic [7:0][SampleW-1:0]        d_i,
  input  logic [mtv_pkg::TolW-1:0]       tol_i,
  output logic                           done_o,
  output logic [2:0][FracBits:0]         xyz_o
);
  localparam int unsigned VW = SampleW + 2;
  localparam int unsigned SW = $clog2(SearchSteps + 1);
  localparam logic [FracBits:0] One = (FracBits+1)'(1) << FracBits;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_ADD} state_e;

  state_e               state_q;
  logic [2:0]           op_q;
  logic [SW-1:0]        iter_q;
  logic [FracBits:0]    p_q, step_q;
  logic [2:0]           v0_q, v1_q;
  logic signed [VW-1:0] c_q [6];

  logic signed [VW-1:0] la, lb, lr, tolx;
  logic [FracBits:0]    lt;
  logic [2:0][FracBits:0] pos;

  function automatic logic [FracBits:0] axis(input logic a, input logic b,
                                             input logic [FracBits:0] p);
    logic [FracBits:0] r;
    if (a == b) r = a ? One : '0;
    else        r = a ? One - p : p;
    return r;
  endfunction

  function automatic logic signed [VW-1:0] dx(input logic [SampleW-1:0] v);
    return VW'($signed(v));
  endfunction

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pos[k] = axis(v0_q[2-k], v1_q[2-k], p_q);
    end
  end

  // op 0..3: x blends, 4..5: y blends, 6: z blend
  always_comb begin
    la = '0; lb = '0; lt = pos[0];
    unique case (op_q)
      3'd0: begin la = dx(d_i[0]); lb = dx(d_i[4]); lt = pos[0]; end
      3'd1: begin la = dx(d_i[1]); lb = dx(d_i[5]); lt = pos[0]; end
      3'd2: begin la = dx(d_i[2]); lb = dx(d_i[6]); lt = pos[0]; end
      3'd3: begin la = dx(d_i[3]); lb = dx(d_i[7]); lt = pos[0]; end
      3'd4: begin la = c_q[0]; lb = c_q[2]; lt = pos[1]; end
      3'd5: begin la = c_q[1]; lb = c_q[3]; lt = pos[1]; end
      default: begin la = c_q[4]; lb = c_q[5]; lt = pos[2]; end
    endcase
  end

  mtv_lerp_unit #(.FracBits(FracBits), .SampleW(SampleW)) u_lerp (
    .clk_i(clk_i), .a_i(la), .b_i(lb), .t_i(lt), .r_o(lr)
  );

  assign tolx  = VW'($signed({1'b0, tol_i}));
  assign xyz_o = pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_o  <= 1'b0;
      op_q    <= '0;
      iter_q  <= '0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (go_i) begin
            v0_q    <= v0_i;
            v1_q    <= v1_i;
            p_q     <= One >> 1;
            step_q  <= One >> 2;
            op_q    <= '0;
            iter_q  <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL: state_q <= S_ADD;
        S_ADD: begin
          if (op_q < 3'd4) c_q[op_q] <= lr;
          else if (op_q < 3'd6) c_q[op_q - 3'd2 + 3'd2] <= lr;
          if (op_q != 3'd6) begin
            op_q    <= op_q + 3'd1;
            state_q <= S_MUL;
          end else begin
            op_q <= '0;
            if (lr < -tolx) p_q <= p_q + step_q;
            else if (lr > tolx) p_q <= p_q - step_q;
            step_q <= step_q >> 1;
            if (lr >= -tolx && lr <= tolx || iter_q == SW'(SearchSteps - 1)) begin
              state_q <= S_IDLE;
              done_o  <= 1'b1;
            end else begin
              iter_q  <= iter_q + SW'(1);
              state_q <= S_MUL;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// File: sv/marching_tetrahedra_voxel.sv
// Channel   | Dir | Handshake                 | Payload
// voxel     | in  | start, accepted !busy     | voxel_i  (mtv_pkg::voxel_t)
// triangle  | out | valid_o one-cycle strobe  | result_o (mtv_pkg::tri_t)
// config    | in  | cfg_we_i                  | cfg_wdata_i (zero_tolerance)
//
// One voxel at a time; busy drops in the cycle that shows the last triangle word.
// Each probe is 7 blends on the one lerp unit; a vertex takes up to SEARCH_STEPS
// probes, a triangle 3 vertices, and a full voxel holds up to 12 triangles; a
// voxel with no crossing runs only the 6 tetra scans.
// Reset is asynchronous, active low; tolerance resets to 1.
// The receiver cannot stall: each triangle is shown for one cycle only.
module marching_tetrahedra_voxel #(
  parameter int unsigned SEARCH_STEPS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  mtv_pkg::voxel_t             voxel_i,
  output logic                        valid_o,
  output mtv_pkg::tri_t               result_o,
  input  logic                        cfg_we_i,
  input  logic [mtv_pkg::TolW-1:0]    cfg_wdata_i
);
  localparam int unsigned SAMPLE_WIDTH        = mtv_pkg::SampleW;
  localparam int unsigned COORD_FRACTION_BITS = mtv_pkg::CoordFracBits;
  localparam int unsigned FB = COORD_FRACTION_BITS;

  typedef enum logic [2:0] {S_IDLE, S_TET, S_TRI, S_VERT, S_WAIT, S_EMIT} state_e;

  state_e                   state_q;
  logic [mtv_pkg::TolW-1:0] tol_q;
  logic [7:0][SAMPLE_WIDTH-1:0] d_q;
  logic [2:0]               tet_q;    // tetrahedron 0..5
  logic                     tri_q;    // triangle within tetra
  logic [1:0]               vert_q;   // vertex within triangle
  logic [3:0]               key_q;
  logic                     any_q;    // a triangle is held for output
  logic                     go;
  logic                     done;
  logic [2:0][FB:0]         xyz;
  logic [2:0]               ca, cb;
  logic [11:0]              row;
  logic [1:0]               fpos, epos;
  logic [3:0]               key_d;
  logic [3:0][2:0]          corner;
  mtv_pkg::tri_t            hold_q;
  logic [8:0][FB:0]         coords_q;

  // corners of current tetrahedron: 0, 7, ring[t], ring[t+1]
  assign corner[0] = 3'd0;
  assign corner[1] = 3'd7;
  assign corner[2] = mtv_pkg::ring_corner(tet_q);
  assign corner[3] = mtv_pkg::ring_corner(tet_q + 3'd1);

  always_comb begin
    for (int v = 0; v < 4; v++) key_d[v] = d_q[corner[v]][SAMPLE_WIDTH-1];
  end

  assign row  = mtv_pkg::edge_row(key_q, tri_q);
  assign fpos = row[vert_q*4+2 +: 2];
  assign epos = row[vert_q*4 +: 2];
  assign ca   = corner[fpos];
  assign cb   = corner[epos];
  assign go   = (state_q == S_VERT);

  mtv_search #(.SearchSteps(SEARCH_STEPS), .FracBits(FB), .SampleW(SAMPLE_WIDTH)) u_search (
    .clk_i(clk_i), .rst_ni(rst_ni), .go_i(go), .v0_i(ca), .v1_i(cb),
    .d_i(d_q), .tol_i(tol_q), .done_o(done), .xyz_o(xyz)
  );

  assign busy = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tol_q   <= mtv_pkg::TolW'(1);
      valid_o <= 1'b0;
      any_q   <= 1'b0;
      tet_q   <= '0;
      tri_q   <= 1'b0;
      vert_q  <= '0;
    end else begin
      valid_o <= 1'b0;
      if (cfg_we_i) tol_q <= cfg_wdata_i;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            d_q     <= voxel_i;
            tet_q   <= '0;
            any_q   <= 1'b0;
            state_q <= S_TET;
          end
        end
        S_TET: begin
          key_q   <= key_d;
          tri_q   <= 1'b0;
          vert_q  <= '0;
          if (mtv_pkg::tri_count(key_d) != 2'd0) state_q <= S_VERT;
          else if (tet_q == 3'd5) state_q <= S_EMIT;
          else tet_q <= tet_q + 3'd1;
        end
        S_VERT: state_q <= S_WAIT;
        S_WAIT: begin
          if (done) begin
            coords_q[vert_q*3 + 0] <= xyz[0];
            coords_q[vert_q*3 + 1] <= xyz[1];
            coords_q[vert_q*3 + 2] <= xyz[2];
            if (vert_q != 2'd2) begin
              vert_q  <= vert_q + 2'd1;
              state_q <= S_VERT;
            end else begin
              state_q <= S_TRI;
            end
          end
        end
        S_TRI: begin
          // new triangle ready: push the previous one out, it is not last
          if (any_q) begin
            result_o <= hold_q;
            valid_o  <= 1'b1;
          end
          any_q <= 1'b1;
          hold_q <= '{vert_a_x: mtv_pkg::CoordW'(coords_q[0]),
                      vert_a_y: mtv_pkg::CoordW'(coords_q[1]),
                      vert_a_z: mtv_pkg::CoordW'(coords_q[2]),
                      vert_b_x: mtv_pkg::CoordW'(coords_q[3]),
                      vert_b_y: mtv_pkg::CoordW'(coords_q[4]),
                      vert_b_z: mtv_pkg::CoordW'(coords_q[5]),
                      vert_c_x: mtv_pkg::CoordW'(coords_q[6]),
                      vert_c_y: mtv_pkg::CoordW'(coords_q[7]),
                      vert_c_z: mtv_pkg::CoordW'(coords_q[8]),
                      tetra_index: tet_q, last_triangle: 1'b0};
          vert_q <= '0;
          if (!tri_q && mtv_pkg::tri_count(key_q) == 2'd2) begin
            tri_q   <= 1'b1;
            state_q <= S_VERT;
          end else if (tet_q == 3'd5) begin
            state_q <= S_EMIT;
          end else begin
            tet_q   <= tet_q + 3'd1;
            state_q <= S_TET;
          end
        end
        S_EMIT: begin
          // held triangle goes out flagged as the last one
          if (any_q) begin
            result_o <= {hold_q[$bits(mtv_pkg::tri_t)-1:1], 1'b1};
            valid_o  <= 1'b1;
          end
          any_q   <= 1'b0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// File: sv/mtv_checker.sv
`include "assert_macros.svh"
module mtv_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          valid_o,
  input mtv_pkg::tri_t result_o
);
  `ASSERT_CLK(a_out_while_busy, (valid_o && !result_o.last_triangle) |-> busy, "stray word")
  `ASSERT_CLK(a_tetra_range, valid_o |-> (result_o.tetra_index <= 3'd5), "tetra index out of range")
  `ASSERT_CLK(a_last_ends, (valid_o && result_o.last_triangle) |=> !valid_o, "result after last")
  `ASSERT_CLK(a_accept_busy, (start && !busy) |=> busy, "accepted voxel not busy")
endmodule

bind marching_tetrahedra_voxel mtv_checker u_mtv_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
  .valid_o(valid_o), .result_o(result_o)
);

// File: tb/marching_tetrahedra_voxel_tb.sv
`timescale 1ns / 100ps

module marching_tetrahedra_voxel_tb;

  localparam int unsigned FracBits  = 17;
  localparam longint      OneFx     = 64'sd1 << FracBits;
  localparam int unsigned ProbeMax  = 16;
  localparam int unsigned CW        = mtv_pkg::CoordW;
  localparam int unsigned TW        = mtv_pkg::TolW;
  // Cycles with nothing accepted before the run is called hung. The slowest
  // voxel searches 36 vertices of up to 16 probes each.
  localparam int unsigned StallLimit = 50000;
  // Drain after the last triangle: an empty voxel still scans 6 tetrahedra.
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned MaxReports  = 10;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             start;
  logic             busy;
  mtv_pkg::voxel_t  voxel_i;
  logic             valid_o;
  mtv_pkg::tri_t    result_o;
  logic             cfg_we_i;
  logic [TW-1:0]    cfg_wdata_i;

  always #4 clk_i = ~clk_i;

  marching_tetrahedra_voxel i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .voxel_i     (voxel_i),
    .valid_o     (valid_o),
    .result_o    (result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Triangle predictor plus the queue of triangles still owed by the block.
  class tri_scoreboard;
    logic [TW-1:0]   tol = 1;
    mtv_pkg::tri_t   owed_tris[$];
    int unsigned     mismatches = 0;

    // Edge per vertex as a byte {filled pos, empty pos}, vertex a first.
    logic [23:0] edge_tbl [16][2] = '{
      '{24'h000000, 24'h000000},
      '{24'h020103, 24'h000000},
      '{24'h101213, 24'h000000},
      '{24'h121303, 24'h030212},
      '{24'h202321, 24'h000000},
      '{24'h032321, 24'h210103},
      '{24'h102023, 24'h231310},
      '{24'h231303, 24'h000000},
      '{24'h303132, 24'h000000},
      '{24'h320201, 24'h013132},
      '{24'h123230, 24'h301012},
      '{24'h123202, 24'h000000},
      '{24'h303121, 24'h212030},
      '{24'h312101, 24'h000000},
      '{24'h301020, 24'h000000},
      '{24'h000000, 24'h000000}
    };
    int unsigned tri_num [16] = '{0,1,1,2,1,2,2,1,1,2,2,1,2,1,1,0};
    logic [2:0]  ring [7] = '{3'd6, 3'd4, 3'd5, 3'd1, 3'd3, 3'd2, 3'd6};

    // Rounded-half-up blend; >>> on a signed longint is a floor divide.
    function automatic longint blend(longint a, longint b, longint t);
      return (a * (OneFx - t) + b * t + OneFx / 2) >>> FracBits;
    endfunction

    function automatic longint sample_at(longint d[8], longint x, longint y, longint z);
      longint c0, c1;
      c0 = blend(blend(d[0], d[4], x), blend(d[2], d[6], x), y);
      c1 = blend(blend(d[1], d[5], x), blend(d[3], d[7], x), y);
      return blend(c0, c1, z);
    endfunction

    function automatic longint axis_coord(bit a, bit b, longint p);
      if (a == b) return a ? OneFx : 0;
      return a ? OneFx - p : p;
    endfunction

    // Binary search along the edge from filled corner f to empty corner e.
    function automatic logic [3*CW-1:0] edge_vertex(longint d[8], logic [2:0] f,
                                                    logic [2:0] e);
      longint p, stp, r, tl;
      p   = OneFx / 2;
      stp = OneFx / 4;
      tl  = longint'(tol);
      for (int i = 0; i < ProbeMax; i++) begin
        r = sample_at(d, axis_coord(f[2], e[2], p), axis_coord(f[1], e[1], p),
                      axis_coord(f[0], e[0], p));
        if (r < -tl) p += stp;
        else if (r > tl) p -= stp;
        else break;
        stp = stp >>> 1;
      end
      return {CW'(axis_coord(f[2], e[2], p)), CW'(axis_coord(f[1], e[1], p)),
              CW'(axis_coord(f[0], e[0], p))};
    endfunction

    function void note_voxel(mtv_pkg::voxel_t v);
      longint          d[8];
      logic [2:0]      corner[4];
      logic [3:0]      key;
      logic [23:0]     row;
      logic [7:0]      eb;
      logic [3*CW-1:0] xyz[3];
      mtv_pkg::tri_t   t;
      int              first_new;
      first_new = owed_tris.size();
      for (int i = 0; i < 8; i++) d[i] = longint'($signed(v[16*i +: 16]));
      for (int k = 0; k < 6; k++) begin
        corner[0] = 3'd0;
        corner[1] = 3'd7;
        corner[2] = ring[k];
        corner[3] = ring[k+1];
        // zero counts as empty
        for (int c = 0; c < 4; c++) key[c] = d[corner[c]] < 0;
        for (int n = 0; n < tri_num[key]; n++) begin
          row = edge_tbl[key][n];
          for (int j = 0; j < 3; j++) begin
            eb = row[8*(2-j) +: 8];
            xyz[j] = edge_vertex(d, corner[eb[5:4]], corner[eb[1:0]]);
          end
          t = {xyz[0], xyz[1], xyz[2], 3'(k), 1'b0};
          owed_tris.push_back(t);
        end
      end
      if (owed_tris.size() > first_new) owed_tris[owed_tris.size()-1].last_triangle = 1'b1;
    endfunction

    function void field_diff(string name, logic [CW-1:0] exp_v, logic [CW-1:0] got_v,
                             inout bit bad);
      if (exp_v !== got_v) begin
        bad = 1;
        if (mismatches < MaxReports)
          $display("triangle %s: expected %0d, got %0d", name, exp_v, got_v);
      end
    endfunction

    function void check_tri(mtv_pkg::tri_t got);
      mtv_pkg::tri_t exp_t;
      bit            bad;
      bad = 0;
      if (owed_tris.size() == 0) begin
        if (mismatches < MaxReports)
          $display("unexpected triangle word %h", got);
        mismatches++;
        return;
      end
      exp_t = owed_tris.pop_front();
      field_diff("vert_a_x", exp_t.vert_a_x, got.vert_a_x, bad);
      field_diff("vert_a_y", exp_t.vert_a_y, got.vert_a_y, bad);
      field_diff("vert_a_z", exp_t.vert_a_z, got.vert_a_z, bad);
      field_diff("vert_b_x", exp_t.vert_b_x, got.vert_b_x, bad);
      field_diff("vert_b_y", exp_t.vert_b_y, got.vert_b_y, bad);
      field_diff("vert_b_z", exp_t.vert_b_z, got.vert_b_z, bad);
      field_diff("vert_c_x", exp_t.vert_c_x, got.vert_c_x, bad);
      field_diff("vert_c_y", exp_t.vert_c_y, got.vert_c_y, bad);
      field_diff("vert_c_z", exp_t.vert_c_z, got.vert_c_z, bad);
      field_diff("tetra_index", CW'(exp_t.tetra_index), CW'(got.tetra_index), bad);
      field_diff("last_triangle", CW'(exp_t.last_triangle), CW'(got.last_triangle), bad);
      if (bad) mismatches++;
    endfunction
  endclass

  tri_scoreboard sb = new();
  int unsigned   idle_cycles = 0;
  int unsigned   no_gap_left = 0;

  // Triangles are strobed for one cycle; sample on every edge.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) sb.check_tri(result_o);
  end

  // Watchdog: counts cycles with neither a voxel nor a triangle word moving.
  always @(posedge clk_i) begin
    if (!rst_ni || valid_o || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("marching_tetrahedra_voxel: mismatch");
        $finish;
      end
    end
  end

  function automatic logic signed [15:0] rand_sample(int unsigned mode);
    logic signed [15:0] picks[5] = '{16'sh8000, 16'sh7fff, 16'sh0000, -16'sd1, 16'sd1};
    case (mode)
      0: return 16'($urandom_range(0, 32767));
      1: return -16'sd1 - 16'($urandom_range(0, 32767));
      2, 3, 4, 5: return 16'($urandom);
      6, 7, 8: return 16'($signed($urandom_range(0, 600)) - 300);
      default: return picks[$urandom_range(0, 4)];
    endcase
  endfunction

  function automatic mtv_pkg::voxel_t rand_voxel();
    mtv_pkg::voxel_t v;
    int unsigned     mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 8; i++) v[16*i +: 16] = rand_sample(mode);
    return v;
  endfunction

  // Called at a rising edge; returns at the edge where the voxel is taken.
  task automatic send_voxel(mtv_pkg::voxel_t v);
    int unsigned gap;
    if (no_gap_left > 0) begin
      gap = 0;
      no_gap_left--;
    end else begin
      if ($urandom_range(0, 15) == 0) no_gap_left = $urandom_range(5, 20);
      gap = $urandom_range(0, 13);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start   <= 1'b1;
    voxel_i <= v;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_voxel(v);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.owed_tris.size() != 0) @(posedge clk_i);
    // an empty voxel may still be scanning
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_tolerance(logic [TW-1:0] val);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.tol = val;
  endtask

  task automatic random_voxels(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_voxel(rand_voxel());
  endtask

  initial begin
    mtv_pkg::voxel_t v;
    rst_ni      = 1'b0;
    start       = 1'b0;
    voxel_i     = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_tolerance(15'd1);
    // Directed: uniform voxels (no crossing, zero as empty), extremes,
    // each single filled corner, and alternating signs.
    send_voxel({8{16'sh7fff}});
    send_voxel({8{16'sh8000}});
    send_voxel({8{16'sh0000}});
    send_voxel({16'sh0000, 16'sh7fff, 16'sh0000, 16'sh7fff,
                16'sh0000, 16'sh7fff, 16'sh0000, 16'sh7fff});
    for (int i = 0; i < 8; i++) begin
      v = {8{16'sh7fff}};
      v[16*i +: 16] = 16'sh8000;
      send_voxel(v);
    end
    send_voxel({16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
                16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff});
    send_voxel({16'sh0001, -16'sd1, 16'sh0001, -16'sd1,
                -16'sd1, 16'sh0001, -16'sd1, 16'sh0001});
    send_voxel({16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
    send_voxel({16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
                -16'sd1, -16'sd1, -16'sd1, -16'sd1});
    random_voxels(40);

    // exact crossing only: searches run all steps unless a probe hits zero
    write_tolerance(15'd0);
    random_voxels(50);
    // widest tolerance: searches stop at the first probe
    write_tolerance(15'h7fff);
    random_voxels(40);
    write_tolerance(15'($urandom_range(2, 3000)));
    random_voxels(60);
    write_tolerance(15'd3);
    random_voxels(55);

    drain();
    if (sb.mismatches == 0) begin
      $display("marching_tetrahedra_voxel: match");
    end else begin
      $display("marching_tetrahedra_voxel: mismatch");
    end
    $finish;
  end

endmodule
